FILE: rtl/pcgc_pkg.sv
package pcgc_pkg;

    typedef enum logic [2:0] {
        MSG_OUT    = 3'd0,
        MSG_OVER   = 3'd1,
        MSG_HELD   = 3'd2,
        MSG_LONG   = 3'd3,
        MSG_CLICK  = 3'd4,
        MSG_DOUBLE = 3'd5
    } msg_t;

    typedef enum logic [1:0] {
        HOVER_OUT  = 2'd0,
        HOVER_OVER = 2'd1,
        HOVER_DOWN = 2'd2
    } hover_t;

    typedef enum logic [1:0] {
        REG_AREA_WIDTH   = 2'd0,
        REG_AREA_HEIGHT  = 2'd1,
        REG_LONG_PRESS   = 2'd2,
        REG_DOUBLE_CLICK = 2'd3
    } reg_idx_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    localparam int unsigned IN_BITS    = 66;
    localparam int unsigned IN_TDATA_W = 72;
    localparam int unsigned OUT_TDATA_W = 8;

    // Packed so that pointer_x lands in the lowest bits.
    typedef struct packed {
        logic [31:0]        now_ticks;
        logic               visible;
        logic               button_down;
        logic signed [15:0] pointer_y;
        logic signed [15:0] pointer_x;
    } item_t;

    typedef struct packed {
        logic [14:0] area_width;
        logic [14:0] area_height;
        logic [15:0] long_press_ticks;
        logic [15:0] double_click_ticks;
    } cfg_t;

    typedef struct packed {
        logic        held_before;
        logic        previous_was_short;
        logic [31:0] press_start_time;
        logic [31:0] release_time;
        msg_t        last_message;
    } track_t;

    typedef struct packed {
        logic   contact;
        hover_t hover_state;
        msg_t   message;
    } result_t;

endpackage

FILE: rtl/pointer_click_gesture_classifier_top.sv
// Pointer click gesture classifier. Each input transaction carries one pointer
// sample (position, button level, visible flag and a wrapping 32-bit timestamp)
// or, when tuser is high, a command that clears all contact tracking. Every
// input transaction produces exactly one output transaction holding a message
// (out, over, held down, long press end, click, double click), the hover state
// that follows from it and a contact flag. The position is hit-tested as
// 0 <= x < area_width and 0 <= y <= area_height. A release is a long press end
// when it comes more than long_press_ticks after the press; otherwise it is a
// click, or a double click when the previous press was also short and this
// press began less than double_click_ticks after the previous release. A
// sample that is not visible changes nothing and repeats the last message.
// The block takes one transaction per clock cycle while the output is not
// stalled. Each transaction passes through the input register, where the hit
// test, the two 32-bit time differences and the state update are done, and is
// then held in the output register until taken. The input register keeps
// accepting while a result waits, as long as it is itself free. Configuration
// registers are written through cfg_we/cfg_addr/cfg_wdata and should only be
// changed while no transaction is in flight.
module pointer_click_gesture_classifier_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata, from bit 0: pointer_x[15:0], pointer_y[31:16], button_down[32],
    // visible[33], now_ticks[65:34], zero padding[71:66].
    input  logic [pcgc_pkg::IN_TDATA_W-1:0] s_tdata,
    // tuser: op (0 sample the pointer, 1 clear contact tracking).
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata, from bit 0: message[2:0], hover_state[4:3], contact[5],
    // zero padding[7:6].
    output logic [pcgc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    pcgc_pkg::cfg_t    cfg_reg;
    pcgc_pkg::track_t  track_reg;
    pcgc_pkg::track_t  track_next;
    pcgc_pkg::item_t   item_reg;
    pcgc_pkg::result_t result_next;
    pcgc_pkg::result_t result_reg;

    logic in_valid_reg;
    logic in_op_reg;
    logic out_valid_reg;
    logic advance;
    logic accept;

    // The input stage moves into the output register whenever the output is
    // empty or being drained this cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.area_width         <= 15'd0;
            cfg_reg.area_height        <= 15'd0;
            cfg_reg.long_press_ticks   <= 16'd500;
            cfg_reg.double_click_ticks <= 16'd300;
        end else if (cfg_we) begin
            unique case (pcgc_pkg::reg_idx_t'(cfg_addr))
                pcgc_pkg::REG_AREA_WIDTH:   cfg_reg.area_width <= cfg_wdata[14:0];
                pcgc_pkg::REG_AREA_HEIGHT:  cfg_reg.area_height <= cfg_wdata[14:0];
                pcgc_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ticks <= cfg_wdata;
                pcgc_pkg::REG_DOUBLE_CLICK: cfg_reg.double_click_ticks <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg  <= pcgc_pkg::item_t'(s_tdata[pcgc_pkg::IN_BITS-1:0]);
            in_op_reg <= s_tuser;
        end
    end

    pcgc_core u_core (
        .op         (in_op_reg),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .track      (track_reg),
        .track_next (track_next),
        .result     (result_next)
    );

    // Tracking state commits when the item leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg.held_before        <= 1'b0;
            track_reg.previous_was_short <= 1'b0;
            track_reg.press_start_time   <= '0;
            track_reg.release_time       <= '0;
            track_reg.last_message       <= pcgc_pkg::MSG_OUT;
        end else if (in_valid_reg && advance) begin
            track_reg <= track_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

    // A clear command always reports the out message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && advance && (in_op_reg == pcgc_pkg::OP_RESET)
        |=> m_tdata[2:0] == pcgc_pkg::MSG_OUT)
        else $error("clear command did not report the out message");

    // A held-down message is only ever kept while a press is tracked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        track_reg.last_message == pcgc_pkg::MSG_HELD |-> track_reg.held_before)
        else $error("held message without a tracked press");

    // The input side only stalls when a finished result is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // Contact is reported exactly when the hover state is down.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5] == (m_tdata[4:3] == pcgc_pkg::HOVER_DOWN)))
        else $error("contact flag disagrees with hover state");

endmodule

FILE: rtl/pcgc_core.sv
module pcgc_core (
    input  logic            op,
    input  pcgc_pkg::item_t item,
    input  pcgc_pkg::cfg_t  cfg,
    input  pcgc_pkg::track_t track,
    output pcgc_pkg::track_t track_next,
    output pcgc_pkg::result_t result
);

    logic        inside_x;
    logic        inside_y;
    logic        over;
    logic [31:0] press_len;
    logic [31:0] release_gap;
    logic        is_long;
    logic        is_double;

    // A negative coordinate has its sign bit set and fails the test for its axis.
    assign inside_x = !item.pointer_x[15] &&
                      (item.pointer_x[14:0] < cfg.area_width);
    assign inside_y = !item.pointer_y[15] &&
                      (item.pointer_y[14:0] <= cfg.area_height);
    assign over     = inside_x && inside_y;

    // Both differences wrap modulo 2^32.
    assign press_len   = item.now_ticks - track.press_start_time;
    assign release_gap = track.press_start_time - track.release_time;
    assign is_long     = press_len > {16'd0, cfg.long_press_ticks};
    assign is_double   = track.previous_was_short &&
                         (release_gap < {16'd0, cfg.double_click_ticks});

    always_comb begin
        track_next = track;
        if (op == pcgc_pkg::OP_RESET) begin
            track_next.held_before        = 1'b0;
            track_next.previous_was_short = 1'b0;
            track_next.press_start_time   = '0;
            track_next.release_time       = '0;
            track_next.last_message       = pcgc_pkg::MSG_OUT;
        end else if (item.visible) begin
            if (item.button_down && (over || track.held_before)) begin
                if (!track.held_before) begin
                    track_next.press_start_time = item.now_ticks;
                end
                track_next.held_before  = 1'b1;
                track_next.last_message = pcgc_pkg::MSG_HELD;
            end else if (track.held_before) begin
                // Release, inside or outside the area.
                track_next.held_before  = 1'b0;
                track_next.release_time = item.now_ticks;
                if (is_long) begin
                    track_next.previous_was_short = 1'b0;
                    track_next.last_message       = pcgc_pkg::MSG_LONG;
                end else begin
                    track_next.previous_was_short = 1'b1;
                    track_next.last_message = is_double ? pcgc_pkg::MSG_DOUBLE
                                                        : pcgc_pkg::MSG_CLICK;
                end
            end else begin
                // A press that begins outside the area is not tracked.
                track_next.last_message = over ? pcgc_pkg::MSG_OVER
                                               : pcgc_pkg::MSG_OUT;
            end
        end
    end

    always_comb begin
        result.message = track_next.last_message;
        case (track_next.last_message) inside
            pcgc_pkg::MSG_OVER, pcgc_pkg::MSG_LONG: begin
                result.hover_state = pcgc_pkg::HOVER_OVER;
            end
            pcgc_pkg::MSG_HELD, pcgc_pkg::MSG_CLICK, pcgc_pkg::MSG_DOUBLE: begin
                result.hover_state = pcgc_pkg::HOVER_DOWN;
            end
            default: begin
                result.hover_state = pcgc_pkg::HOVER_OUT;
            end
        endcase
        result.contact = (result.hover_state == pcgc_pkg::HOVER_DOWN);
    end

endmodule
